FILE: sv/base64_decoder_unit_defines.svh
// Assertion macros for the base64 decoder unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BASE64_DECODER_UNIT_DEFINES_SVH
`define BASE64_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define B64D_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/b64d_pkg.sv
// Shared types, constants and the alphabet lookup of the base64 decoder.
// No dependencies.
package b64d_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [7:0] CHAR_PAD     = 8'h3d;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [5:0] LOWER_BASE   = 6'd26;
    localparam logic [5:0] DIGIT_BASE   = 6'd52;

    localparam logic [1:0] POS_LAST = 2'd3;

    typedef struct packed {
        logic       missing;
        logic [5:0] value;
    } sextet_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] num_bytes;
        logic       message_end;
    } group_t;

    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t s;
        logic [7:0] d;
        s.missing = 1'b0;
        s.value   = 6'd0;
        d         = 8'd0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
        begin
            d       = ch - CHAR_UPPER_A;
            s.value = d[5:0];
        end
        else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
        begin
            d       = ch - CHAR_LOWER_A;
            s.value = d[5:0] + LOWER_BASE;
        end
        else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9)
        begin
            d       = ch - CHAR_DIGIT_0;
            s.value = d[5:0] + DIGIT_BASE;
        end
        else if (ch == CHAR_PLUS)
        begin
            s.value = SEXTET_PLUS;
        end
        else if (ch == CHAR_SLASH)
        begin
            s.value = SEXTET_SLASH;
        end
        else
        begin
            s.missing = 1'b1;
        end
        return s;
    endfunction

endpackage

FILE: sv/b64d_if.sv
// Channel interfaces of the base64 decoder: character input and byte output.
// No dependencies.
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       message_last;

    modport source (output valid, output char_code, output message_last, input ready);
    modport sink   (input valid, input char_code, input message_last, output ready);
endinterface

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output data_byte, output byte_valid,
                    output run_last, output message_end, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input run_last, input message_end, output ready);
endinterface

FILE: sv/base64_decoder_unit.sv
// Base64 decoder top level: front end, group queue, back end. Uses b64d_pkg, b64d_if.
// A result passes the group queue, then the output register. Throughput: one character per cycle
// in unless queue_full; one result per cycle out from the output register while byte_out is ready;
// a full group of four characters gives three results, so the queue absorbs end-of-message bursts.
// Reset: rst_n clears group state, queue pointers and output valid at once; decoder state
// also returns to its reset values after every message end.
`include "base64_decoder_unit_defines.svh"

module base64_decoder_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    b64d_char_if.sink    char_in,
    b64d_byte_if.source  byte_out
);

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              not_empty;
    logic              bare_push;
    b64d_pkg::group_t  push_data;
    b64d_pkg::group_t  head;

    b64d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (queue_full),
        .not_empty (not_empty)
    );

    b64d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .byte_out  (byte_out)
    );

    assign bare_push = push && (push_data.num_bytes == 2'd0);

    `B64D_ASSERT_IMPLY(a_no_overflow, push, !queue_full, "group pushed into full queue")
    `B64D_ASSERT_IMPLY(a_no_underflow, pop, not_empty, "group popped from empty queue")
    `B64D_ASSERT_IMPLY(a_bare_at_end, bare_push, push_data.message_end, "bare group mid message")
    `B64D_ASSERT_NEXT(a_pop_frees_slot, pop && !push, !queue_full, "queue still full after pop")

endmodule

FILE: sv/b64d_front.sv
// Front end: accepts characters, tracks group state and builds byte groups.
// Depends on b64d_pkg and b64d_char_if.
module b64d_front
(
    input  logic              clk,
    input  logic              rst_n,
    b64d_char_if.sink         char_in,
    input  logic              queue_full,
    output logic              push,
    output b64d_pkg::group_t  push_data
);

    logic [1:0]        pos_reg;
    logic [1:0]        pos_next;
    logic [5:0]        held_reg [3];
    logic [5:0]        held_next [3];
    logic              stopped_reg;
    logic              stopped_next;
    logic              accept;
    logic              take;
    logic              complete;
    b64d_pkg::sextet_t sx;

    assign char_in.ready = !queue_full;
    assign accept        = char_in.valid && !queue_full;
    assign sx            = b64d_pkg::sextet_of(char_in.char_code);
    assign take          = !stopped_reg && !sx.missing;
    assign complete      = take && (pos_reg == b64d_pkg::POS_LAST);
    assign push          = accept && (complete || char_in.message_last);

    always_comb
    begin
        held_next    = held_reg;
        pos_next     = pos_reg;
        stopped_next = stopped_reg || sx.missing;
        if (complete)
        begin
            pos_next = 2'd0;
        end
        else if (take)
        begin
            held_next[pos_reg] = sx.value;
            pos_next           = pos_reg + 2'd1;
        end
    end

    always_comb
    begin
        push_data.message_end = char_in.message_last;
        if (complete)
        begin
            push_data.byte0     = {held_reg[0], held_reg[1][5:4]};
            push_data.byte1     = {held_reg[1][3:0], held_reg[2][5:2]};
            push_data.byte2     = {held_reg[2][1:0], sx.value};
            push_data.num_bytes = 2'd3;
        end
        else
        begin
            push_data.byte0     = {held_next[0], held_next[1][5:4]};
            push_data.byte1     = {held_next[1][3:0], held_next[2][5:2]};
            push_data.byte2     = 8'd0;
            push_data.num_bytes = (pos_next >= 2'd2) ? (pos_next - 2'd1) : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 2'd0;
            stopped_reg <= 1'b0;
            held_reg    <= '{default: 6'd0};
        end
        else if (accept)
        begin
            if (char_in.message_last)
            begin
                pos_reg     <= 2'd0;
                stopped_reg <= 1'b0;
                held_reg    <= '{default: 6'd0};
            end
            else
            begin
                pos_reg     <= pos_next;
                stopped_reg <= stopped_next;
                held_reg    <= held_next;
            end
        end
    end

endmodule

FILE: sv/b64d_queue.sv
// Short queue of byte groups between front and back end.
// Depends on b64d_pkg.
module b64d_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64d_pkg::group_t  push_data,
    input  logic              pop,
    output b64d_pkg::group_t  head,
    output logic              full,
    output logic              not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    b64d_pkg::group_t  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign head      = mem[rd_ptr_reg];
    assign full      = (count_reg == CNT_MAX);
    assign not_empty = (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/b64d_back.sv
// Back end: splits each byte group into result items behind an output register.
// Depends on b64d_pkg and b64d_byte_if.
module b64d_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  b64d_pkg::group_t  head,
    input  logic              not_empty,
    output logic              pop,
    b64d_byte_if.source       byte_out
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] data_reg;
    logic       byte_valid_reg;
    logic       run_last_reg;
    logic       message_end_reg;
    logic       load;
    logic       last_in_group;
    logic [7:0] sel_byte;

    assign last_in_group = (head.num_bytes == 2'd0) || (idx_reg == head.num_bytes - 2'd1);
    assign load          = not_empty && (!out_valid_reg || byte_out.ready);
    assign pop           = load && last_in_group;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.byte0;
            2'd1:    sel_byte = head.byte1;
            default: sel_byte = head.byte2;
        endcase
        if (head.num_bytes == 2'd0)
        begin
            sel_byte = 8'd0;
        end
    end

    assign byte_out.valid       = out_valid_reg;
    assign byte_out.data_byte   = data_reg;
    assign byte_out.byte_valid  = byte_valid_reg;
    assign byte_out.run_last    = run_last_reg;
    assign byte_out.message_end = message_end_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg        <= sel_byte;
            byte_valid_reg  <= (head.num_bytes != 2'd0);
            run_last_reg    <= last_in_group;
            message_end_reg <= head.message_end && last_in_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last_in_group ? 2'd0 : idx_reg + 2'd1;
            end
            else if (byte_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: tb/b64d_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the base64 decoder unit: predicts decoded bytes from accepted characters
// and compares them with accepted results. Depends on b64d_pkg and b64d_if.
module b64d_checker
(
    input  logic  clk,
    input  logic  rst_n,
    b64d_char_if  char_ch,
    b64d_byte_if  byte_ch,
    output int    fail_count,
    output int    pending
);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_end;
    } byte_result_t;

    byte_result_t expected_bytes[$];

    logic [1:0] group_pos;
    logic [5:0] held[3];
    logic       stopped;

    function automatic logic alphabet_value(input logic [7:0] ch, output logic [5:0] v);
        logic [7:0] offset;
        logic       found;
        offset = 8'd0;
        found  = 1'b1;
        if (ch >= b64d_pkg::CHAR_UPPER_A && ch <= b64d_pkg::CHAR_UPPER_Z)
            offset = ch - b64d_pkg::CHAR_UPPER_A;
        else if (ch >= b64d_pkg::CHAR_LOWER_A && ch <= b64d_pkg::CHAR_LOWER_Z)
            offset = ch - b64d_pkg::CHAR_LOWER_A + 8'(b64d_pkg::LOWER_BASE);
        else if (ch >= b64d_pkg::CHAR_DIGIT_0 && ch <= b64d_pkg::CHAR_DIGIT_9)
            offset = ch - b64d_pkg::CHAR_DIGIT_0 + 8'(b64d_pkg::DIGIT_BASE);
        else if (ch == b64d_pkg::CHAR_PLUS)
            offset = 8'(b64d_pkg::SEXTET_PLUS);
        else if (ch == b64d_pkg::CHAR_SLASH)
            offset = 8'(b64d_pkg::SEXTET_SLASH);
        else
            found = 1'b0;
        v = offset[5:0];
        return found;
    endfunction

    function automatic byte_result_t data_result(input logic [7:0] b);
        byte_result_t r;
        r.data_byte   = b;
        r.byte_valid  = 1'b1;
        r.run_last    = 1'b0;
        r.message_end = 1'b0;
        return r;
    endfunction

    task automatic decode_char(input logic [7:0] ch, input logic last);
        byte_result_t run[$];
        byte_result_t bare;
        logic [5:0]   v;
        if (!stopped)
        begin
            if (!alphabet_value(ch, v))
                stopped = 1'b1;
            else if (group_pos == b64d_pkg::POS_LAST)
            begin
                run = {run, data_result({held[0], held[1][5:4]})};
                run = {run, data_result({held[1][3:0], held[2][5:2]})};
                run = {run, data_result({held[2][1:0], v})};
                group_pos = 2'd0;
            end
            else
            begin
                held[group_pos] = v;
                group_pos       = group_pos + 2'd1;
            end
        end
        if (last)
        begin
            if (group_pos >= 2'd2)
                run = {run, data_result({held[0], held[1][5:4]})};
            if (group_pos == b64d_pkg::POS_LAST)
                run = {run, data_result({held[1][3:0], held[2][5:2]})};
            if (run.size() == 0)
            begin
                bare = '0;
                run  = {run, bare};
            end
            run[run.size() - 1].message_end = 1'b1;
            group_pos = '0;
            held      = '{default: '0};
            stopped   = 1'b0;
        end
        if (run.size() > 0)
        begin
            run[run.size() - 1].run_last = 1'b1;
            foreach (run[i])
                expected_bytes = {expected_bytes, run[i]};
        end
    endtask

    always @(posedge clk)
    begin
        byte_result_t exp_b;
        if (!rst_n)
        begin
            fail_count = 0;
            group_pos  = '0;
            held       = '{default: '0};
            stopped    = 1'b0;
            expected_bytes.delete();
            pending <= 0;
        end
        else
        begin
            if (char_ch.valid && char_ch.ready)
                decode_char(char_ch.char_code, char_ch.message_last);
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected result: data_byte %0h byte_valid %0b",
                           byte_ch.data_byte, byte_ch.byte_valid);
                    fail_count++;
                end
                else
                begin
                    exp_b = expected_bytes.pop_front();
                    if (byte_ch.data_byte !== exp_b.data_byte)
                    begin
                        $error("data_byte: expected %0h, got %0h",
                               exp_b.data_byte, byte_ch.data_byte);
                        fail_count++;
                    end
                    if (byte_ch.byte_valid !== exp_b.byte_valid)
                    begin
                        $error("byte_valid: expected %0b, got %0b",
                               exp_b.byte_valid, byte_ch.byte_valid);
                        fail_count++;
                    end
                    if (byte_ch.run_last !== exp_b.run_last)
                    begin
                        $error("run_last: expected %0b, got %0b",
                               exp_b.run_last, byte_ch.run_last);
                        fail_count++;
                    end
                    if (byte_ch.message_end !== exp_b.message_end)
                    begin
                        $error("message_end: expected %0b, got %0b",
                               exp_b.message_end, byte_ch.message_end);
                        fail_count++;
                    end
                end
            end
            pending <= expected_bytes.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the base64 decoder unit bench: clock, reset, character stimulus and output stalls.
// Checking is done by b64d_checker; depends on b64d_pkg, b64d_if and base64_decoder_unit.
module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 480;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   burst_left  = 0;
    int   items_sent  = 0;
    int   stall_mode  = 0;
    int   stall_left  = 0;

    logic [7:0] msg[$];

    b64d_char_if char_ch ();
    b64d_byte_if byte_ch ();

    base64_decoder_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_ch),
        .byte_out (byte_ch)
    );

    b64d_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_ch    (char_ch),
        .byte_ch    (byte_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("base64_decoder_unit test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            byte_ch.ready <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 80);
            end
            stall_left--;
            case (stall_mode)
                0:       byte_ch.ready <= 1'b1;
                1:       byte_ch.ready <= 1'($urandom_range(0, 1));
                2:       byte_ch.ready <= (cycle_count % 5) != 0;
                default: byte_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    function automatic logic [7:0] alpha_char(input int idx);
        if (idx < 26)
            return b64d_pkg::CHAR_UPPER_A + 8'(idx);
        else if (idx < 52)
            return b64d_pkg::CHAR_LOWER_A + 8'(idx - 26);
        else if (idx < 62)
            return b64d_pkg::CHAR_DIGIT_0 + 8'(idx - 52);
        else if (idx == 62)
            return b64d_pkg::CHAR_PLUS;
        else
            return b64d_pkg::CHAR_SLASH;
    endfunction

    function automatic logic [7:0] foreign_char();
        case ($urandom_range(0, 2))
            0:       return b64d_pkg::CHAR_PAD;
            1:       return 8'h80 | 8'($urandom_range(0, 127));
            default: return 8'($urandom_range(0, 8'h2a));
        endcase
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            msg = {msg, s[i]};
    endtask

    task automatic send_item(input logic [7:0] ch, input logic last);
        if (burst_left == 0)
        begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 30);
        end
        char_ch.valid        <= 1'b1;
        char_ch.char_code    <= ch;
        char_ch.message_last <= last;
        @(posedge clk);
        while (!char_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_message();
        foreach (msg[i])
            send_item(msg[i], i == msg.size() - 1);
        msg.delete();
    endtask

    task automatic random_message();
        int kind;
        int groups;
        int tail;
        int counted;
        int stop_at;
        kind   = $urandom_range(0, 9);
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
        tail   = $urandom_range(0, 3);
        for (int i = 0; i < groups * 4 + tail; i++)
            msg = {msg, alpha_char($urandom_range(0, 63))};
        if (tail >= 2 && $urandom_range(0, 1) == 1)
            repeat (4 - tail) msg = {msg, b64d_pkg::CHAR_PAD};
        if (msg.size() == 0)
            msg = {msg, alpha_char($urandom_range(0, 63))};
        if (kind == 7 || kind == 8)
        begin
            stop_at      = $urandom_range(0, msg.size() - 1);
            msg[stop_at] = foreign_char();
        end
        else if (kind == 9)
        begin
            msg.delete();
            repeat ($urandom_range(1, 8)) msg = {msg, 8'($urandom_range(0, 255))};
        end
        counted = msg.size();
        send_message();
        items_sent += counted;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        char_ch.valid        = 1'b0;
        char_ch.char_code    = 8'd0;
        char_ch.message_last = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_text("TWFu");
        send_message();
        add_text("TWE=");
        send_message();
        add_text("Q");
        send_message();
        add_text("AZaz09+/");
        send_message();
        add_text("//");
        msg = {msg, 8'hff};
        add_text("A");
        send_message();
        msg = {msg, 8'h00};
        send_message();
        msg = {msg, b64d_pkg::CHAR_PAD};
        send_message();

        while (items_sent < RANDOM_ITEMS)
            random_message();
        char_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("base64_decoder_unit test passed");
        else
            $display("base64_decoder_unit test failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/b64d_pkg.sv
sv/b64d_if.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_decoder_unit.sv
tb/b64d_checker.sv
tb/testbench.sv
